// File: rtl/core/md5_pkg.sv
// Shared types, round constants and microcode for the MD5 engine.
package md5_pkg;

  localparam int unsigned PcWidth  = 4;
  localparam int unsigned BufWords = 16;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadMark = 8'h80;

  // Datapath operation of one microcode step
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_NOP,
    OP_PAD,
    OP_LOAD,
    OP_RND_A,
    OP_RND_B,
    OP_FOLD,
    OP_EMIT
  } op_e;

  // Jump condition of one microcode step
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_ACCEPT,
    C_FULL,
    C_NOT_LAST,
    C_PAD_END,
    C_ROUND_MORE,
    C_NOT_DONE,
    C_EMIT_END
  } cond_e;

  // Program addresses
  typedef enum logic [PcWidth-1:0] {
    PC_WAIT    = 4'd0,
    PC_DISP    = 4'd1,
    PC_TAIL    = 4'd2,
    PC_PAD     = 4'd3,
    PC_LOAD    = 4'd4,
    PC_RND_A   = 4'd5,
    PC_RND_B   = 4'd6,
    PC_FOLD    = 4'd7,
    PC_CHKLEN  = 4'd8,
    PC_EMIT    = 4'd9,
    PC_RESTART = 4'd10
  } pc_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    logic  hold;    // stay on this step when the condition is false
    pc_e   target;
  } ucode_t;

  // Microcode ROM: taken jump goes to target, else hold or fall through
  function automatic ucode_t ucode_rom(input pc_e pc);
    ucode_t w;
    unique case (pc)
      PC_WAIT:    w = '{OP_WAIT,  C_ACCEPT,     1'b1, PC_DISP};
      PC_DISP:    w = '{OP_NOP,   C_FULL,       1'b0, PC_LOAD};
      PC_TAIL:    w = '{OP_NOP,   C_NOT_LAST,   1'b0, PC_WAIT};
      PC_PAD:     w = '{OP_PAD,   C_PAD_END,    1'b1, PC_LOAD};
      PC_LOAD:    w = '{OP_LOAD,  C_NEVER,      1'b0, PC_WAIT};
      PC_RND_A:   w = '{OP_RND_A, C_NEVER,      1'b0, PC_WAIT};
      PC_RND_B:   w = '{OP_RND_B, C_ROUND_MORE, 1'b0, PC_RND_A};
      PC_FOLD:    w = '{OP_FOLD,  C_NOT_LAST,   1'b0, PC_WAIT};
      PC_CHKLEN:  w = '{OP_NOP,   C_NOT_DONE,   1'b0, PC_PAD};
      PC_EMIT:    w = '{OP_EMIT,  C_EMIT_END,   1'b1, PC_RESTART};
      PC_RESTART: w = '{OP_NOP,   C_ALWAYS,     1'b0, PC_WAIT};
      default:    w = '{OP_NOP,   C_ALWAYS,     1'b0, PC_WAIT};
    endcase
    return w;
  endfunction

  // Additive constant of each round
  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Rotate amount, picked by round stage and low round bits
  function automatic logic [4:0] round_shift(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by each round
  function automatic logic [3:0] round_word(input logic [5:0] i);
    logic [3:0] g;
    unique case (i[5:4])
      2'd0:    g = i[3:0];
      2'd1:    g = 4'(i[3:0] * 4'd5 + 4'd1);
      2'd2:    g = 4'(i[3:0] * 4'd3 + 4'd5);
      2'd3:    g = 4'(i[3:0] * 4'd7);
      default: g = i[3:0];
    endcase
    return g;
  endfunction

  // Nonlinear function of each stage
  function automatic logic [31:0] round_f(input logic [1:0] stage, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (stage)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (d & b) | (~d & c);
      2'd2:    f = b ^ c ^ d;
      2'd3:    f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/core/md5_ram.sv
// Generic single-write, single-read RAM with registered read data.
module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/md5_message_digest.sv
// MD5 engine top level: microcode sequencer, block buffer and round datapath.
//
// Message bytes enter one per input transaction; has_byte_i marks a real byte and
// is_last_i ends the message, so an empty message is a single transaction with
// only is_last_i set. A byte passes the wait, dispatch and tail check steps of the
// sequencer. The byte that completes a 64-byte block skips the tail check and runs
// a compression instead: one load step, then 64 rounds of two steps each (sum,
// then rotate and add) on one shared round unit, then a fold into the chaining
// words. The end of a message writes padding bytes up to the block end and runs
// one or two compressions, each followed by a length check; the digest then
// leaves as four output transactions, words A to D, each a 32-bit little-endian
// word, and a restart step readies the engine for the next message. Input is not
// taken while a block compresses, padding runs or the digest is being sent.
module md5_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);
  import md5_pkg::*;

  // Sequencer state
  pc_e         pc_q, pc_d;
  ucode_t      uw;
  logic        cond_true;

  // Control registers
  logic [60:0] count_q, count_d;
  logic [5:0]  pos_q, pos_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [1:0]  widx_q, widx_d;
  logic        full_q, full_d;
  logic        last_q, last_d;
  logic        mark_q, mark_d;
  logic        len_ok_q, len_ok_d;
  logic        done_q, done_d;

  // Payload registers
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] a_d, b_d, c_d, d_d;
  logic [31:0] sum_q, sum_d;
  logic [23:0] asm_q, asm_d;

  // Datapath signals
  logic        in_acc, out_acc;
  logic        byte_we;
  logic [7:0]  byte_w;
  logic [63:0] bits_w;
  logic [7:0]  len_byte;
  logic        ram_we;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;
  logic [63:0] rot_w;

  assign uw      = ucode_rom(pc_q);
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Handshake and result outputs
  always_comb begin
    in_ready_o    = (uw.op == OP_WAIT);
    out_valid_o   = (uw.op == OP_EMIT);
    digest_word_o = chain_q[widx_q];
    word_index_o  = widx_q;
    last_word_o   = (widx_q == 2'd3);
  end

  // Jump condition select
  always_comb begin
    unique case (uw.cond)
      C_NEVER:      cond_true = 1'b0;
      C_ALWAYS:     cond_true = 1'b1;
      C_ACCEPT:     cond_true = in_acc;
      C_FULL:       cond_true = full_q;
      C_NOT_LAST:   cond_true = !last_q;
      C_PAD_END:    cond_true = (pos_q == 6'd63);
      C_ROUND_MORE: cond_true = (rnd_q != 6'd63);
      C_NOT_DONE:   cond_true = !done_q;
      C_EMIT_END:   cond_true = out_acc && (widx_q == 2'd3);
      default:      cond_true = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (cond_true) begin
      pc_d = uw.target;
    end else if (uw.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_e'(pc_q + 4'd1);
    end
  end

  // Byte path into the block buffer: message byte, pad mark, zero or length
  assign bits_w   = {count_q, 3'b000};
  assign len_byte = bits_w[{pos_q[2:0], 3'b000} +: 8];

  always_comb begin
    byte_we = 1'b0;
    byte_w  = data_byte_i;
    if (uw.op == OP_WAIT) begin
      byte_we = in_acc && has_byte_i;
    end else if (uw.op == OP_PAD) begin
      byte_we = 1'b1;
      if (!mark_q) begin
        byte_w = PadMark;
      end else if (len_ok_q && (pos_q[5:3] == 3'b111)) begin
        byte_w = len_byte;
      end else begin
        byte_w = 8'h00;
      end
    end
  end

  assign ram_we    = byte_we && (pos_q[1:0] == 2'b11);
  assign ram_raddr = round_word(rnd_d);
  assign rot_w     = {sum_q, sum_q} << round_shift(rnd_q);

  md5_ram #(
    .Width(32),
    .Depth(BufWords)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q[5:2]),
    .wdata_i({byte_w, asm_q}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Control word decode into register updates
  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    rnd_d    = rnd_q;
    widx_d   = widx_q;
    full_d   = full_q;
    last_d   = last_q;
    mark_d   = mark_q;
    len_ok_d = len_ok_q;
    done_d   = done_q;
    chain_d  = chain_q;
    a_d      = a_q;
    b_d      = b_q;
    c_d      = c_q;
    d_d      = d_q;
    sum_d    = sum_q;
    asm_d    = asm_q;

    if (byte_we) begin
      pos_d = pos_q + 6'd1;
      asm_d = {byte_w, asm_q[23:8]};
    end

    unique case (uw.op)
      OP_WAIT: begin
        if (in_acc) begin
          last_d = is_last_i;
          if (has_byte_i) begin
            count_d = count_q + 61'd1;
            full_d  = (pos_q == 6'd63);
          end
        end
      end
      OP_PAD: begin
        if (!mark_q) begin
          mark_d   = 1'b1;
          len_ok_d = (pos_q[5:3] != 3'b111);
        end
      end
      OP_LOAD: begin
        full_d = 1'b0;
        rnd_d  = '0;
        a_d    = chain_q[0];
        b_d    = chain_q[1];
        c_d    = chain_q[2];
        d_d    = chain_q[3];
      end
      OP_RND_A: begin
        sum_d = a_q + round_f(rnd_q[5:4], b_q, c_q, d_q) + round_k(rnd_q) + ram_rdata;
      end
      OP_RND_B: begin
        rnd_d = rnd_q + 6'd1;
        a_d   = d_q;
        d_d   = c_q;
        c_d   = b_q;
        b_d   = b_q + rot_w[63:32];
      end
      OP_FOLD: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        if (last_q) begin
          done_d   = len_ok_q;
          len_ok_d = 1'b1;
        end
      end
      OP_EMIT: begin
        if (out_acc) begin
          widx_d = widx_q + 2'd1;
        end
      end
      OP_NOP: begin
        // restart step clears the message context
        if (pc_q == PC_RESTART) begin
          chain_d[0] = InitA;
          chain_d[1] = InitB;
          chain_d[2] = InitC;
          chain_d[3] = InitD;
          count_d    = '0;
          pos_d      = '0;
          last_d     = 1'b0;
          mark_d     = 1'b0;
          len_ok_d   = 1'b0;
          done_d     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and chaining registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q       <= PC_WAIT;
      count_q    <= '0;
      pos_q      <= '0;
      rnd_q      <= '0;
      widx_q     <= '0;
      full_q     <= 1'b0;
      last_q     <= 1'b0;
      mark_q     <= 1'b0;
      len_ok_q   <= 1'b0;
      done_q     <= 1'b0;
      chain_q[0] <= InitA;
      chain_q[1] <= InitB;
      chain_q[2] <= InitC;
      chain_q[3] <= InitD;
    end else begin
      pc_q     <= pc_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      rnd_q    <= rnd_d;
      widx_q   <= widx_d;
      full_q   <= full_d;
      last_q   <= last_d;
      mark_q   <= mark_d;
      len_ok_q <= len_ok_d;
      done_q   <= done_d;
      chain_q  <= chain_d;
    end
  end

  // Working registers of the round unit and the byte assembler
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    sum_q <= sum_d;
    asm_q <= asm_d;
  end

`ifndef SYNTH
  // Input and output are never offered in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("input ready while digest is offered");

  // Every accepted transaction is dispatched next
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> (pc_q == PC_DISP))
    else $error("accepted transaction not dispatched");

  // Compression always starts at round zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == OP_LOAD) |=> (rnd_q == 6'd0) && (pc_q == PC_RND_A))
    else $error("compression did not start at round zero");

  // Final digest word leads to restart with index back at A
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_word_o) |=> (pc_q == PC_RESTART) && (widx_q == 2'd0))
    else $error("no restart after final digest word");

  // Padding never runs without an ended message
  assert property (@(posedge clk_i) disable iff (!rst_ni) (uw.op == OP_PAD) |-> last_q)
    else $error("padding without final transaction");
`endif

endmodule

// File: verif/md5_message_digest_tb.sv
// Self-checking testbench for the MD5 engine: byte stimulus, digest prediction, handshake checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 4000;  // cycles with no transaction before giving up
  localparam int unsigned DrainWait  = 300;   // settle time after the last digest word
  localparam int unsigned ShowMax    = 10;

  // Additive constant of each round, straight from the MD5 definition
  localparam logic [31:0] RoundConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };
  // Rotate amounts: four per stage
  localparam int RotAmount [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        is_end;
  } digest_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready_o;
  logic [7:0]  data_byte;
  logic        has_byte;
  logic        is_last;
  logic        out_valid_o;
  logic        out_ready;
  logic [31:0] digest_word_o;
  logic [1:0]  word_index_o;
  logic        last_word_o;

  // Predictor state
  logic [31:0]  chain_val [4];
  logic [7:0]   blk_buf [64];
  logic [60:0]  msg_len;
  digest_beat_t digest_q [$];

  // Run bookkeeping
  bit          send_idle_on;
  bit          recv_stall_on;
  int unsigned mismatch_cnt;
  int unsigned beats_checked;
  int unsigned msgs_sent;
  int unsigned items_sent;
  int unsigned quiet_cycles;

  md5_message_digest dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte),
    .has_byte_i   (has_byte),
    .is_last_i    (is_last),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .digest_word_o(digest_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void md5_restart();
    chain_val[0] = 32'h67452301;
    chain_val[1] = 32'hefcdab89;
    chain_val[2] = 32'h98badcfe;
    chain_val[3] = 32'h10325476;
    msg_len      = '0;
  endfunction

  // One 64-round compression of the block buffer into the chaining words
  function automatic void md5_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t, sum;
    int g, s;
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk_buf[4*i+3], blk_buf[4*i+2], blk_buf[4*i+1], blk_buf[4*i]};
    end
    a = chain_val[0];
    b = chain_val[1];
    c = chain_val[2];
    d = chain_val[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      sum = a + f + RoundConst[i] + w[g];
      s   = RotAmount[(i / 16) * 4 + (i % 4)];
      t   = d;
      d   = c;
      c   = b;
      b   = b + ((sum << s) | (sum >> (32 - s)));
      a   = t;
    end
    chain_val[0] += a;
    chain_val[1] += b;
    chain_val[2] += c;
    chain_val[3] += d;
  endfunction

  // Apply one accepted input transaction; queue the digest words it yields
  function automatic void md5_absorb(input logic [7:0] din, input logic hb, input logic lst);
    int pos;
    logic [63:0] bit_len;
    digest_beat_t beat;
    if (hb) begin
      pos = int'(msg_len[5:0]);
      blk_buf[pos] = din;
      msg_len = msg_len + 61'd1;
      if (pos == 63) md5_compress();
    end
    if (lst) begin
      bit_len = {msg_len, 3'b000};
      pos = int'(msg_len[5:0]);
      blk_buf[pos] = 8'h80;
      pos++;
      // no room left for the length: pad out and compress an extra block
      if (pos > 56) begin
        for (int k = pos; k < 64; k++) blk_buf[k] = 8'h00;
        md5_compress();
        pos = 0;
      end
      for (int k = pos; k < 56; k++) blk_buf[k] = 8'h00;
      for (int k = 0; k < 8; k++) blk_buf[56 + k] = bit_len[8*k +: 8];
      md5_compress();
      for (int k = 0; k < 4; k++) begin
        beat.word   = chain_val[k];
        beat.idx    = 2'(k);
        beat.is_end = (k == 3);
        digest_q.push_back(beat);
      end
      md5_restart();
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one input transaction and wait for it to be taken
  task automatic send_item(input logic [7:0] din, input logic hb, input logic lst);
    int gap;
    if (send_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid  <= 1'b1;
    data_byte <= din;
    has_byte  <= hb;
    is_last   <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    md5_absorb(din, hb, lst);
    if (hb || lst) items_sent++;
  endtask

  // A whole message of random bytes, with stray no-op transactions mixed in when noise is set
  task automatic send_message(input int len, input bit noise);
    bit tail_flag_only;
    tail_flag_only = (len == 0) || ($urandom_range(0, 2) == 0);
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !tail_flag_only && (i == len - 1));
    end
    if (tail_flag_only) send_item(8'($urandom), 1'b0, 1'b1);
    msgs_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  // Receiver readiness: random stall bursts while enabled
  initial begin : ready_drive
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (recv_stall_on && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checker

  // Compare each digest transaction with the oldest predicted word
  always @(posedge clk_i) begin
    digest_beat_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (digest_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= ShowMax)
          $display("%0t: unexpected digest word %h idx %0d last %0b", $realtime,
                   digest_word_o, word_index_o, last_word_o);
      end else begin
        want = digest_q.pop_front();
        beats_checked++;
        if (digest_word_o !== want.word || word_index_o !== want.idx ||
            last_word_o !== want.is_end) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ShowMax)
            $display("%0t: digest mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                     $realtime, want.word, want.idx, want.is_end,
                     digest_word_o, word_index_o, last_word_o);
        end
      end
    end
  end

  // Watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Empty message, ignored transaction, "a", "abc", ff 00 80, single bytes at both extremes
  task automatic test_directed();
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    msgs_sent += 6;
  endtask

  // Random messages; a quarter of them sit on the padding and block edges
  task automatic test_random_messages();
    int len;
    int start_items;
    start_items = items_sent;
    while ((items_sent - start_items) < 75) begin
      send_idle_on  = ($urandom_range(0, 3) != 0);
      recv_stall_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: begin
          case ($urandom_range(0, 5))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            default: len = 65;
          endcase
        end
        default: len = $urandom_range(0, 12);
      endcase
      send_message(len, 1'b1);
    end
  endtask

  // Back-to-back messages with both sides always ready
  task automatic test_streaming();
    send_idle_on  = 1'b0;
    recv_stall_on = 1'b0;
    send_message(64, 1'b0);
    send_message($urandom_range(0, 8), 1'b0);
    send_message(1, 1'b0);
  endtask

  initial begin
    in_valid      = 1'b0;
    data_byte     = 8'h00;
    has_byte      = 1'b0;
    is_last       = 1'b0;
    rst_ni        = 1'b0;
    send_idle_on  = 1'b1;
    recv_stall_on = 1'b1;
    msgs_sent     = 0;
    items_sent    = 0;
    md5_restart();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_messages();
    test_streaming();
    drop_valid();

    // drain the remaining digest words, then look for stray output
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d messages (%0d byte/end transactions), %0d digest words checked",
             msgs_sent, items_sent, beats_checked);
    $display("empty and block-edge lengths, ignored transactions, random sender and receiver stalls");
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/md5_pkg.sv
rtl/core/md5_ram.sv
rtl/core/md5_message_digest.sv
verif/md5_message_digest_tb.sv
